@@ hw/rtl/gcbp_pkg.sv @@
// shared types, constants and the pin lookup for the gpio command byte processor
// no dependencies; imported by every module of the block but gcbp_ram
package gcbp_pkg;

   localparam int FRAME_BYTES_DEF = 18;
   localparam int PIN_COUNT_DEF   = 32;
   localparam int PORT_COUNT_DEF  = 5;

   localparam int BYTE_W      = 8;
   localparam int LATCH_W     = 40;
   localparam int PORT_MAX    = 5;
   localparam int PIN_POS_W   = 6;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [BYTE_W-1:0]  REJECT_MARK = 8'hFF;
   localparam logic [LATCH_W-1:0] LATCH_RESET = {LATCH_W{1'b1}};

   // command byte bits
   localparam int CMD_FRAME_BIT = 7;
   localparam int CMD_QUERY_BIT = 6;
   localparam int CMD_LEVEL_BIT = 5;

   // pin table: port in the high nibble, bit in the low three bits
   localparam logic [7:0] PIN_MAP [32] = '{
      8'h24, 8'h23, 8'h22, 8'h21, 8'h20, 8'h40, 8'h37, 8'h36,
      8'h35, 8'h34, 8'h33, 8'h25, 8'h26, 8'h27, 8'h44, 8'h45,
      8'h41, 8'h46, 8'h07, 8'h06, 8'h05, 8'h04, 8'h03, 8'h02,
      8'h01, 8'h00, 8'h42, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14
   };

   typedef enum logic {
      ENT_SINGLE,
      ENT_WALK
   } entry_kind_type;

   // one unit of work handed from the front to the back
   typedef struct packed {
      entry_kind_type      kind;
      logic                match;
      logic [BYTE_W-1:0]   byte_val;
      logic [BYTE_W-1:0]   sum;
      logic                bank;
      logic [LATCH_W-1:0]  latch;
   } entry_type;

   typedef struct packed {
      logic                 hit;
      logic [PIN_POS_W-1:0] pos;
   } pin_type;

   function automatic pin_type pin_bit(input logic [7:0] cmd, input int pin_count,
                                       input int port_count);
      pin_type    res;
      logic [7:0] entry;
      logic [3:0] port;
      entry   = PIN_MAP[cmd[4:0]];
      port    = entry[7:4];
      res.hit = (int'(cmd[4:0]) < pin_count) && (int'(port) < port_count) &&
                (int'(port) < PORT_MAX);
      res.pos = {port[2:0], entry[2:0]};
      return res;
   endfunction

endpackage

@@ hw/rtl/gcbp_ram.sv @@
// generic simple dual port ram, one write and one registered read port
// no dependencies
module gcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/gcbp_front.sv @@
// front end: accepts command bytes, runs the frame counter, latch and checksum
// depends on gcbp_pkg
module gcbp_front #(
   parameter int FRAME_BYTES = gcbp_pkg::FRAME_BYTES_DEF,
   parameter int PIN_COUNT   = gcbp_pkg::PIN_COUNT_DEF,
   parameter int PORT_COUNT  = gcbp_pkg::PORT_COUNT_DEF,
   localparam int IDX_W      = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1,
   localparam int RAM_AW     = IDX_W + 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [gcbp_pkg::BYTE_W-1:0]     req_command_byte,
   input  logic [gcbp_pkg::LATCH_W-1:0]    req_pin_levels,
   input  logic                            walk_active,
   input  logic                            q_full,
   output logic                            q_push,
   output gcbp_pkg::entry_type             q_data,
   output logic                            wr_en,
   output logic [RAM_AW-1:0]               wr_addr,
   output logic [gcbp_pkg::BYTE_W-1:0]     wr_data
);
   import gcbp_pkg::*;

   localparam int POS_W = $clog2(FRAME_BYTES + 2);
   localparam logic [POS_W-1:0] POS_SUM = POS_W'(FRAME_BYTES + 1);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [LATCH_W-1:0] latch_ff, latch_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic               commit_bank_ff, commit_bank_in;

   logic               is_idle, is_sum, is_frame, acc, match;
   pin_type            pb;
   logic [LATCH_W-1:0] latch_new;
   logic [BYTE_W-1:0]  query_byte;

   assign is_idle  = (pos_ff == '0);
   assign is_sum   = (pos_ff == POS_SUM);
   assign is_frame = !is_idle && !is_sum;

   // frame bytes land in the store the back end may be reading
   assign req_stall = is_frame ? walk_active : q_full;
   assign acc       = req_valid && !req_stall;

   assign pb    = pin_bit(req_command_byte, PIN_COUNT, PORT_COUNT);
   assign match = (sum_ff == req_command_byte);

   always_comb begin
      latch_new = latch_ff;
      if (pb.hit) begin
         latch_new[pb.pos] = req_command_byte[CMD_LEVEL_BIT];
      end
      query_byte = req_command_byte;
      query_byte[CMD_LEVEL_BIT] = pb.hit && req_pin_levels[pb.pos];
   end

   assign wr_en   = acc && is_frame;
   assign wr_addr = {~commit_bank_ff, IDX_W'(pos_ff - POS_W'(1))};
   assign wr_data = req_command_byte;

   always_comb begin
      pos_in         = pos_ff;
      latch_in       = latch_ff;
      sum_in         = sum_ff;
      commit_bank_in = commit_bank_ff;
      q_push         = 1'b0;
      q_data.kind     = ENT_SINGLE;
      q_data.match    = 1'b0;
      q_data.byte_val = req_command_byte;
      q_data.sum      = sum_ff;
      q_data.bank     = commit_bank_ff;
      q_data.latch    = latch_ff;
      if (acc) begin
         if (is_idle) begin
            q_push = 1'b1;
            if (req_command_byte[CMD_FRAME_BIT]) begin
               pos_in = POS_W'(1);
               sum_in = '0;
            end else if (req_command_byte[CMD_QUERY_BIT]) begin
               q_data.byte_val = query_byte;
            end else begin
               latch_in     = latch_new;
               q_data.latch = latch_new;
            end
         end else if (is_sum) begin
            q_push       = 1'b1;
            q_data.kind  = ENT_WALK;
            q_data.match = match;
            q_data.bank  = match ? ~commit_bank_ff : commit_bank_ff;
            if (match) begin
               commit_bank_in = ~commit_bank_ff;
            end
            pos_in = '0;
         end else begin
            sum_in = sum_ff + req_command_byte;
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         latch_ff       <= LATCH_RESET;
         commit_bank_ff <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         latch_ff       <= latch_in;
         commit_bank_ff <= commit_bank_in;
      end
      sum_ff <= sum_in;
   end

endmodule

@@ hw/rtl/gcbp_queue.sv @@
// short queue of work entries between the front and the back end
// depends on gcbp_pkg
module gcbp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gcbp_pkg::entry_type push_data,
   input  logic                pop,
   output gcbp_pkg::entry_type head,
   output logic                full,
   output logic                empty
);
   import gcbp_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/gcbp_back.sv @@
// back end: settings store, reply sequencer and the result register
// depends on gcbp_pkg and gcbp_ram
module gcbp_back #(
   parameter int FRAME_BYTES = gcbp_pkg::FRAME_BYTES_DEF,
   localparam int IDX_W      = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1,
   localparam int RAM_AW     = IDX_W + 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   input  gcbp_pkg::entry_type             q_head,
   output logic                            q_pop,
   output logic                            busy,
   input  logic                            wr_en,
   input  logic [RAM_AW-1:0]               wr_addr,
   input  logic [gcbp_pkg::BYTE_W-1:0]     wr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [gcbp_pkg::BYTE_W-1:0]     rsp_reply_byte,
   output logic                            rsp_last_of_run,
   output logic [gcbp_pkg::LATCH_W-1:0]    rsp_port_drive,
   output logic                            rsp_reset_request
);
   import gcbp_pkg::*;

   localparam int RAM_DEPTH = 2 << IDX_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HEAD,
      ST_READ,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   entry_type          ent_ff, ent_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [1:0]         head_ff, head_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [LATCH_W-1:0] rsp_drive_ff, rsp_drive_in;
   logic               rsp_rst_ff, rsp_rst_in;

   logic               vld_ff [RAM_DEPTH];
   logic               vld_rd_ff;
   logic               rd_en, out_free, idx_last;
   logic [RAM_AW-1:0]  rd_addr;
   logic [BYTE_W-1:0]  rd_data, store_byte, head_byte;

   gcbp_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // entries never written read as the all-zero settings of reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RAM_DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
         vld_rd_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_addr    = {ent_ff.bank, idx_ff};
   assign store_byte = vld_rd_ff ? rd_data : '0;
   assign idx_last   = (idx_ff == IDX_W'(FRAME_BYTES - 1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign busy       = (state_ff != ST_IDLE);

   always_comb begin
      case (head_ff)
         2'd0:    head_byte = REJECT_MARK;
         2'd1:    head_byte = ent_ff.sum;
         default: head_byte = ent_ff.byte_val;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      ent_in       = ent_ff;
      idx_in       = idx_ff;
      head_in      = head_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_rst_in   = rsp_rst_ff;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if (q_head.kind == ENT_SINGLE) begin
                  if (out_free) begin
                     q_pop        = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_byte_in  = q_head.byte_val;
                     rsp_last_in  = 1'b1;
                     rsp_drive_in = q_head.latch;
                     rsp_rst_in   = 1'b0;
                  end
               end else begin
                  q_pop    = 1'b1;
                  ent_in   = q_head;
                  idx_in   = '0;
                  head_in  = '0;
                  state_in = q_head.match ? ST_READ : ST_HEAD;
               end
            end
         end
         ST_HEAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = head_byte;
               rsp_last_in  = 1'b0;
               rsp_drive_in = ent_ff.latch;
               rsp_rst_in   = 1'b0;
               head_in      = head_ff + 2'd1;
               if (head_ff == 2'd2) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = store_byte;
               rsp_last_in  = idx_last;
               rsp_drive_in = ent_ff.latch;
               rsp_rst_in   = ent_ff.match;
               if (idx_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ent_ff       <= ent_in;
      idx_ff       <= idx_in;
      head_ff      <= head_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_rst_ff   <= rsp_rst_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reply_byte    = rsp_byte_ff;
   assign rsp_last_of_run   = rsp_last_ff;
   assign rsp_port_drive    = rsp_drive_ff;
   assign rsp_reset_request = rsp_rst_ff;

endmodule

@@ hw/rtl/gpio_command_byte_processor.sv @@
// top level of the gpio command byte processor
// depends on gcbp_pkg, gcbp_front, gcbp_queue, gcbp_back (and gcbp_ram below it)
//
// Takes one command byte per transaction together with a snapshot of the pin
// levels, and returns reply bytes, the last one of each run flagged by
// rsp_last_of_run; rsp_port_drive carries the output latch as it stood after
// the command. A single command (echo, pin query, pin set or clear) passes the
// front end, the two-entry work queue and the reply register before it shows up
// on rsp; the next byte can be taken every cycle while the queue has room.
// Settings frame bytes are taken one per cycle and produce no reply, but wait
// while the back end is still replaying an earlier frame or the queue holds an
// entry. A checksum byte produces FRAME_BYTES replies on a match, or
// FRAME_BYTES + 3 on a mismatch; each stored byte passes a read state and an
// emit state because the settings store has a registered read port. The store
// holds two banks, committed and staging, and a match simply swaps their roles.
// No clearing pass runs after reset.
module gpio_command_byte_processor #(
   parameter int FRAME_BYTES = gcbp_pkg::FRAME_BYTES_DEF,
   parameter int PIN_COUNT   = gcbp_pkg::PIN_COUNT_DEF,
   parameter int PORT_COUNT  = gcbp_pkg::PORT_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [gcbp_pkg::BYTE_W-1:0]     req_command_byte,
   input  logic [gcbp_pkg::LATCH_W-1:0]    req_pin_levels,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [gcbp_pkg::BYTE_W-1:0]     rsp_reply_byte,
   output logic                            rsp_last_of_run,
   output logic [gcbp_pkg::LATCH_W-1:0]    rsp_port_drive,
   output logic                            rsp_reset_request
);
   import gcbp_pkg::*;

   localparam int IDX_W  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int RAM_AW = IDX_W + 1;

   // work queue between front and back
   logic               q_push, q_pop, q_full, q_empty;
   entry_type          q_push_data, q_head;

   // staging writes into the settings store
   logic               wr_en;
   logic [RAM_AW-1:0]  wr_addr;
   logic [BYTE_W-1:0]  wr_data;

   // back end still owes replies from a frame, or the queue is not empty
   logic               back_busy, walk_active;

   assign walk_active = back_busy || !q_empty;

   gcbp_front #(
      .FRAME_BYTES (FRAME_BYTES),
      .PIN_COUNT   (PIN_COUNT),
      .PORT_COUNT  (PORT_COUNT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command_byte (req_command_byte),
      .req_pin_levels   (req_pin_levels),
      .walk_active      (walk_active),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_push_data),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data)
   );

   gcbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   gcbp_back #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .busy              (back_busy),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_reply_byte    (rsp_reply_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_port_drive    (rsp_port_drive),
      .rsp_reset_request (rsp_reset_request)
   );

endmodule

@@ hw/rtl/gcbp_checker.sv @@
// port-level checks for the gpio command byte processor, bound to the top level
// depends on gcbp_pkg
module gcbp_checker #(
   parameter int PORT_COUNT = gcbp_pkg::PORT_COUNT_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic [gcbp_pkg::BYTE_W-1:0]     req_command_byte,
   input logic [gcbp_pkg::LATCH_W-1:0]    req_pin_levels,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [gcbp_pkg::BYTE_W-1:0]     rsp_reply_byte,
   input logic                            rsp_last_of_run,
   input logic [gcbp_pkg::LATCH_W-1:0]    rsp_port_drive,
   input logic                            rsp_reset_request
);
   import gcbp_pkg::*;

   localparam int LOW_BITS = 8 * ((PORT_COUNT < PORT_MAX) ? PORT_COUNT : PORT_MAX);
   localparam logic [LATCH_W-1:0] HIGH_MASK =
      ~((LATCH_W'(1) << LOW_BITS) - LATCH_W'(1));

   // reset leaves no reply pending
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("reply valid right after reset");

   // latch bits above the existing ports stay at their reset level
   a_high_latch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_port_drive & HIGH_MASK) == HIGH_MASK))
      else $error("latch bit above the port range changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("reply dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_reply_byte) && $stable(rsp_last_of_run) &&
                                 $stable(rsp_port_drive) && $stable(rsp_reset_request))
      else $error("stalled reply changed");

   // a stalled command transaction is held by the sender
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_command_byte) &&
                                 $stable(req_pin_levels))
      else $error("stalled command changed");

endmodule

bind gpio_command_byte_processor gcbp_checker #(.PORT_COUNT(PORT_COUNT)) u_checker (.*);

@@ tb/gcbp_reply_checker.sv @@
`timescale 1ns / 100ps
// reply checker for the gpio command byte processor: watches both channels, predicts replies
// depends on gcbp_pkg for widths and command bit positions
module gcbp_reply_checker #(
   parameter int FRAME_BYTES = gcbp_pkg::FRAME_BYTES_DEF,
   parameter int PIN_COUNT   = gcbp_pkg::PIN_COUNT_DEF,
   parameter int PORT_COUNT  = gcbp_pkg::PORT_COUNT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [gcbp_pkg::BYTE_W-1:0]  req_command_byte,
   input  logic [gcbp_pkg::LATCH_W-1:0] req_pin_levels,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [gcbp_pkg::BYTE_W-1:0]  rsp_reply_byte,
   input  logic                         rsp_last_of_run,
   input  logic [gcbp_pkg::LATCH_W-1:0] rsp_port_drive,
   input  logic                         rsp_reset_request,
   output int                           fail_count,
   output int                           pending_count
);
   import gcbp_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0]  reply_byte;
      logic               last_of_run;
      logic [LATCH_W-1:0] port_drive;
      logic               reset_request;
   } reply_type;

   // port in the high nibble, bit in the low three
   localparam logic [0:31][7:0] PIN_TABLE = {
      8'h24, 8'h23, 8'h22, 8'h21, 8'h20, 8'h40, 8'h37, 8'h36,
      8'h35, 8'h34, 8'h33, 8'h25, 8'h26, 8'h27, 8'h44, 8'h45,
      8'h41, 8'h46, 8'h07, 8'h06, 8'h05, 8'h04, 8'h03, 8'h02,
      8'h01, 8'h00, 8'h42, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14
   };

   reply_type          reply_queue [$];
   int                 frame_pos;
   logic [LATCH_W-1:0] drive_latch;
   logic [7:0]         staged [FRAME_BYTES];
   logic [7:0]         committed [FRAME_BYTES];
   int                 errors;
   reply_type          got, want;

   function automatic void clear_state();
      frame_pos   = 0;
      drive_latch = {LATCH_W{1'b1}};
      for (int i = 0; i < FRAME_BYTES; i++) begin
         committed[i] = '0;
         staged[i]    = '0;
      end
      reply_queue.delete();
   endfunction

   // latch bit of the pin named by the low five bits, -1 when there is none
   function automatic int pin_position(input logic [7:0] cmd);
      logic [7:0] entry;
      int         port;
      if (int'(cmd[4:0]) >= PIN_COUNT) return -1;
      entry = PIN_TABLE[cmd[4:0]];
      port  = int'(entry[7:4]);
      if (port >= PORT_COUNT || port >= PORT_MAX) return -1;
      return port * 8 + int'(entry[2:0]);
   endfunction

   function automatic void push_reply(input logic [7:0] b, input logic rst);
      reply_type r;
      r.reply_byte    = b;
      r.last_of_run   = 1'b0;
      r.port_drive    = drive_latch;
      r.reset_request = rst;
      reply_queue.push_back(r);
   endfunction

   function automatic void process_byte(input logic [7:0] cmd, input logic [LATCH_W-1:0] lv);
      int         pos;
      int         first;
      logic [7:0] sum;
      logic [7:0] b;
      first = reply_queue.size();
      if (frame_pos == 0) begin
         if (cmd[CMD_FRAME_BIT]) begin
            push_reply(cmd, 1'b0);
            frame_pos = 1;
         end else if (cmd[CMD_QUERY_BIT]) begin
            pos = pin_position(cmd);
            b   = cmd;
            b[CMD_LEVEL_BIT] = (pos >= 0) ? lv[pos] : 1'b0;
            push_reply(b, 1'b0);
         end else begin
            pos = pin_position(cmd);
            if (pos >= 0) drive_latch[pos] = cmd[CMD_LEVEL_BIT];
            push_reply(cmd, 1'b0);
         end
      end else if (frame_pos > FRAME_BYTES) begin
         sum = '0;
         for (int i = 0; i < FRAME_BYTES; i++) sum = sum + staged[i];
         if (sum == cmd) begin
            committed = staged;
            for (int i = 0; i < FRAME_BYTES; i++) push_reply(staged[i], 1'b1);
         end else begin
            staged = committed;
            push_reply(REJECT_MARK, 1'b0);
            push_reply(sum, 1'b0);
            push_reply(cmd, 1'b0);
            for (int i = 0; i < FRAME_BYTES; i++) push_reply(staged[i], 1'b0);
         end
         frame_pos = 0;
      end else begin
         staged[frame_pos - 1] = cmd;
         frame_pos++;
      end
      if (reply_queue.size() > first) reply_queue[reply_queue.size() - 1].last_of_run = 1'b1;
   endfunction

   initial begin
      errors        = 0;
      fail_count    = 0;
      pending_count = 0;
      clear_state();
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
      end else begin
         // replies first: a byte taken at this edge cannot answer at the same edge
         if (rsp_valid && !rsp_stall) begin
            got.reply_byte    = rsp_reply_byte;
            got.last_of_run   = rsp_last_of_run;
            got.port_drive    = rsp_port_drive;
            got.reset_request = rsp_reset_request;
            if (reply_queue.size() == 0) begin
               $error("unexpected reply transaction: reply_byte %h", got.reply_byte);
               errors++;
            end else begin
               want = reply_queue.pop_front();
               if (got.reply_byte !== want.reply_byte) begin
                  $error("reply_byte expected %h actual %h", want.reply_byte, got.reply_byte);
                  errors++;
               end
               if (got.last_of_run !== want.last_of_run) begin
                  $error("last_of_run expected %b actual %b", want.last_of_run, got.last_of_run);
                  errors++;
               end
               if (got.port_drive !== want.port_drive) begin
                  $error("port_drive expected %h actual %h", want.port_drive, got.port_drive);
                  errors++;
               end
               if (got.reset_request !== want.reset_request) begin
                  $error("reset_request expected %b actual %b",
                         want.reset_request, got.reset_request);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) process_byte(req_command_byte, req_pin_levels);
      end
      fail_count    <= errors;
      pending_count <= reply_queue.size();
   end

endmodule

@@ tb/gpio_command_byte_processor_tb.sv @@
`timescale 1ns / 100ps
// top of the gpio command byte processor testbench: clock, reset, stimulus and verdict
// depends on gcbp_pkg, the block and gcbp_reply_checker
module gpio_command_byte_processor_tb;
   import gcbp_pkg::*;

   localparam int FRAME_BYTES  = FRAME_BYTES_DEF;
   localparam int ITEM_TARGET  = 430;
   localparam int HOLD_CYCLES  = 400;
   // worst case is far below this: every byte a full mismatch run behind a slow receiver
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 60;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [BYTE_W-1:0]  req_command_byte;
   logic [LATCH_W-1:0] req_pin_levels;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [BYTE_W-1:0]  rsp_reply_byte;
   logic               rsp_last_of_run;
   logic [LATCH_W-1:0] rsp_port_drive;
   logic               rsp_reset_request;

   int   fail_count;
   int   pending_count;
   int   cycles;
   int   items_sent;
   int   burst_left;
   logic hold_go;

   gpio_command_byte_processor #(
      .FRAME_BYTES (FRAME_BYTES),
      .PIN_COUNT   (PIN_COUNT_DEF),
      .PORT_COUNT  (PORT_COUNT_DEF)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command_byte  (req_command_byte),
      .req_pin_levels    (req_pin_levels),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_reply_byte    (rsp_reply_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_port_drive    (rsp_port_drive),
      .rsp_reset_request (rsp_reset_request)
   );

   gcbp_reply_checker #(
      .FRAME_BYTES (FRAME_BYTES),
      .PIN_COUNT   (PIN_COUNT_DEF),
      .PORT_COUNT  (PORT_COUNT_DEF)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command_byte  (req_command_byte),
      .req_pin_levels    (req_pin_levels),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_reply_byte    (rsp_reply_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_port_drive    (rsp_port_drive),
      .rsp_reset_request (rsp_reset_request),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog: a hung handshake or a lost reply ends the run here
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("gpio_command_byte_processor_tb: errors");
      $finish;
   end

   // receiver: stall pattern switches among four modes at random, plus one long hold-off
   // that lets the queue fill so the block must stall its input
   initial begin
      int  mode;
      int  mode_left;
      int  hold_left;
      int  phase;
      bit  hold_done;
      rsp_stall = 1'b0;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      phase     = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         phase++;
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0: rsp_stall <= 1'b0;                          // free flowing
               1: rsp_stall <= ($urandom_range(0, 3) == 0);   // light
               2: rsp_stall <= ($urandom_range(0, 3) != 0);   // heavy
               default: rsp_stall <= ((phase % 5) < 2);       // periodic
            endcase
         end
      end
   end

   function automatic logic [LATCH_W-1:0] rand_levels();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[LATCH_W-1:0];
   endfunction

   // one request transaction; the sender runs in bursts with idle gaps between them
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [LATCH_W-1:0] lv);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(1, 10);
         burst_left = $urandom_range(1, 24);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      burst_left--;
      @(negedge clock);
      req_valid        <= 1'b1;
      req_command_byte <= b;
      req_pin_levels   <= lv;
      // payload stays put until the block takes it
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // header, FRAME_BYTES settings bytes and a checksum that is right or off by a nonzero amount
   task automatic send_frame(input logic [BYTE_W-1:0] header, input bit good, input bit extremes);
      logic [7:0] sum;
      logic [7:0] b;
      sum = '0;
      send_byte(header, rand_levels());
      for (int i = 0; i < FRAME_BYTES; i++) begin
         if (extremes && i < 2) b = {8{i[0]}};
         else b = 8'($urandom_range(0, 255));
         sum = sum + b;
         send_byte(b, rand_levels());
      end
      if (!good) sum = sum + 8'($urandom_range(1, 255));
      send_byte(sum, rand_levels());
   endtask

   initial begin
      int         pick;
      logic [7:0] cmd;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_command_byte = '0;
      req_pin_levels   = '0;
      hold_go          = 1'b0;
      items_sent       = 0;
      burst_left       = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: clear and set at the ends of the pin table, queries against all-high and
      // all-low levels (bit 5 of the query must be overwritten), then a good settings frame
      send_byte(8'h00, '0);
      send_byte(8'h3F, {LATCH_W{1'b1}});
      send_byte(8'h40, {LATCH_W{1'b1}});
      send_byte(8'h7F, '0);
      send_byte(8'h1F, rand_levels());
      send_frame(8'hFF, 1'b1, 1'b1);

      // random: mostly well-formed commands and frames with random content, some noise
      while (items_sent < ITEM_TARGET) begin
         if (items_sent > 60) hold_go = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            cmd = 8'($urandom_range(0, 127));
            send_byte(cmd, rand_levels());
         end else if (pick < 85) begin
            cmd = 8'($urandom_range(128, 255));
            send_frame(cmd, 1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
         end else begin
            // noise: any byte, which may open a frame in the middle of a sequence
            send_byte(8'($urandom_range(0, 255)), rand_levels());
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // drain: every predicted reply in, then a margin for stray late replies
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("gpio_command_byte_processor_tb: clean");
      end else begin
         $display("gpio_command_byte_processor_tb: errors");
      end
      $finish;
   end

endmodule
